@@ rtl/zzp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzp_pkg
// Shared types and constants of the zigzag pivot detector.
// ----------------------------------------------------------------------------
package zzp_pkg;

    localparam int MAX_SERIES_LEN_DEF = 65536;
    localparam int PRICE_BITS_DEF     = 32;

    localparam int IDX_W   = 16;
    localparam int PRICE_W = 32;
    localparam int THR_W   = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd655;
    localparam logic [THR_W-1:0] THR_MIN   = 16'd66;
    localparam int               FRAC_ONE  = 65536;

    // result queue depth, power of two
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        TREND_NONE = 2'd0,
        TREND_UP   = 2'd1,
        TREND_DOWN = 2'd2
    } trend_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price_sample;
        logic               series_last;
    } zzp_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]   pivot_index;
        logic [PRICE_W-1:0] pivot_price;
        logic               trailing_pivot;
        logic               run_end;
    } zzp_out_t;

    // results of one request, in order: res0 then res1
    typedef struct packed {
        logic [1:0] count;
        zzp_out_t   res0;
        zzp_out_t   res1;
    } zzp_push_t;

endpackage

@@ rtl/zigzag_pivot_detector_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_pivot_detector_top
// Percent-reversal zigzag pivot detector over a stream of Q16.16 prices.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   in_data   (price_sample, series_last)
//   out       out_valid / out_stall out_data  (index, price, trailing, run_end)
//   cfg       cfg_write             cfg_data  (reversal_threshold)
//
// One sample per cycle while the queue has room: input register, one 16x32
// threshold multiply and compare, then a four-entry result queue. Results pass
// through the input register and the queue. A sample is held in the input
// register while the queue lacks space for two results. Reset clears trend
// state, queue and sets the threshold to 655; no clearing pass.
// ----------------------------------------------------------------------------
module zigzag_pivot_detector_top #(
    parameter int MAX_SERIES_LEN = zzp_pkg::MAX_SERIES_LEN_DEF,
    parameter int PRICE_BITS     = zzp_pkg::PRICE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  zzp_pkg::zzp_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output zzp_pkg::zzp_out_t         out_data,
    input  logic                      cfg_write,
    input  logic [zzp_pkg::THR_W-1:0] cfg_data
);
    import zzp_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             in_valid_reg, in_valid_next;
    zzp_in_t          in_reg;
    logic             room;
    logic             proc_fire;
    logic             in_accept;
    zzp_push_t        push;

    assign proc_fire     = in_valid_reg && room;
    assign in_stall      = in_valid_reg && !proc_fire;
    assign in_accept     = in_valid && !in_stall;
    assign in_valid_next = in_accept || (in_valid_reg && !proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                thr_reg <= cfg_data;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_reg <= in_data;
    end

    zzp_core #(
        .MAX_SERIES_LEN (MAX_SERIES_LEN),
        .PRICE_BITS     (PRICE_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (proc_fire),
        .item  (in_reg),
        .thr   (thr_reg),
        .push  (push)
    );

    zzp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // two results only come from the final sample of a series
    a_two_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (proc_fire && in_reg.series_last))
        else $error("two results from a non-final sample");

    // no request pushed without a processed sample
    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> proc_fire)
        else $error("result pushed without a sample");

    // a held sample is neither lost nor changed
    a_hold_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_reg)))
        else $error("held sample lost or changed");

endmodule

@@ rtl/zzp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzp_core
// Trend state and single-pass pivot decision, one sample per cycle while fire is high.
// ----------------------------------------------------------------------------
module zzp_core #(
    parameter int MAX_SERIES_LEN = zzp_pkg::MAX_SERIES_LEN_DEF,
    parameter int PRICE_BITS     = zzp_pkg::PRICE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  zzp_pkg::zzp_in_t         item,
    input  logic [zzp_pkg::THR_W-1:0] thr,
    output zzp_pkg::zzp_push_t       push
);
    import zzp_pkg::*;

    localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int RW = (PW > 17) ? PW : 17;
    localparam int CW = THR_W + RW;
    localparam int IDX_MAX_I = (MAX_SERIES_LEN - 1 > 65535) ? 65535 : MAX_SERIES_LEN - 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(IDX_MAX_I);

    trend_t           trend_reg, trend_next;
    logic [PW-1:0]    ext_price_reg, ext_price_next;
    logic [IDX_W-1:0] ext_idx_reg, ext_idx_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;

    logic [PW-1:0]    price;
    logic [THR_W-1:0] thr_eff;
    logic [PW-1:0]    diff;
    logic [RW-1:0]    ref_val;
    logic [CW-1:0]    lhs, rhs;
    logic             hit;

    logic             conf;
    zzp_out_t         conf_res;
    logic             tail;
    zzp_out_t         tail_res;

    assign price   = item.price_sample[PW-1:0];
    assign thr_eff = (thr < THR_MIN) ? THR_MIN : thr;
    assign diff    = (price >= ext_price_reg) ? price - ext_price_reg
                                              : ext_price_reg - price;
    // zero reference taken as 1.0
    assign ref_val = (ext_price_reg == '0) ? RW'(FRAC_ONE) : RW'(ext_price_reg);
    assign lhs     = CW'({diff, 16'h0000});
    assign rhs     = CW'(thr_eff) * CW'(ref_val);
    assign hit     = lhs >= rhs;

    always_comb
    begin
        trend_next     = trend_reg;
        ext_price_next = ext_price_reg;
        ext_idx_next   = ext_idx_reg;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;
        push           = '0;
        conf           = 1'b0;
        conf_res       = '0;
        tail           = 1'b0;
        tail_res       = '0;

        if (fire)
        begin
            if (count_reg == '0)
            begin
                if (!item.series_last)
                begin
                    trend_next     = TREND_NONE;
                    ext_price_next = price;
                    ext_idx_next   = '0;
                    emit_idx_next  = '0;
                    count_next     = IDX_W'(1);
                    push.count     = 2'd1;
                    push.res0      = '{pivot_index: '0, pivot_price: PRICE_W'(price),
                                       trailing_pivot: 1'b0, run_end: 1'b1};
                end
            end
            else
            begin
                case (trend_reg)
                    TREND_NONE:
                    begin
                        if (hit)
                        begin
                            trend_next     = (price > ext_price_reg) ? TREND_UP : TREND_DOWN;
                            ext_price_next = price;
                            ext_idx_next   = count_reg;
                        end
                    end
                    TREND_UP:
                    begin
                        if (price > ext_price_reg)
                        begin
                            ext_price_next = price;
                            ext_idx_next   = count_reg;
                        end
                        else if (hit)
                        begin
                            conf           = 1'b1;
                            emit_idx_next  = ext_idx_reg;
                            trend_next     = TREND_DOWN;
                            ext_price_next = price;
                            ext_idx_next   = count_reg;
                        end
                    end
                    TREND_DOWN:
                    begin
                        if (price < ext_price_reg)
                        begin
                            ext_price_next = price;
                            ext_idx_next   = count_reg;
                        end
                        else if (hit)
                        begin
                            conf           = 1'b1;
                            emit_idx_next  = ext_idx_reg;
                            trend_next     = TREND_UP;
                            ext_price_next = price;
                            ext_idx_next   = count_reg;
                        end
                    end
                    default:
                    begin
                        trend_next = TREND_NONE;
                    end
                endcase

                conf_res = '{pivot_index: ext_idx_reg, pivot_price: PRICE_W'(ext_price_reg),
                             trailing_pivot: 1'b0, run_end: 1'b0};

                if (count_reg < IDX_MAX)
                    count_next = count_reg + IDX_W'(1);

                // pending extreme flushed on the last sample
                tail     = item.series_last && (emit_idx_next != ext_idx_next);
                tail_res = '{pivot_index: ext_idx_next, pivot_price: PRICE_W'(ext_price_next),
                             trailing_pivot: 1'b1, run_end: 1'b1};

                if (conf && tail)
                begin
                    push.count = 2'd2;
                    push.res0  = conf_res;
                    push.res1  = tail_res;
                end
                else if (conf)
                begin
                    push.count        = 2'd1;
                    push.res0         = conf_res;
                    push.res0.run_end = 1'b1;
                end
                else if (tail)
                begin
                    push.count = 2'd1;
                    push.res0  = tail_res;
                end
            end

            if (item.series_last)
            begin
                trend_next     = TREND_NONE;
                ext_price_next = '0;
                ext_idx_next   = '0;
                count_next     = '0;
                emit_idx_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trend_reg     <= TREND_NONE;
            ext_price_reg <= '0;
            ext_idx_reg   <= '0;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            trend_reg     <= trend_next;
            ext_price_reg <= ext_price_next;
            ext_idx_reg   <= ext_idx_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

endmodule

@@ rtl/zzp_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzp_out_fifo
// Result queue: takes up to two results a cycle, delivers one a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module zzp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  zzp_pkg::zzp_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output zzp_pkg::zzp_out_t  out_data
);
    import zzp_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int LW = AW + 1;

    zzp_out_t        mem_reg [FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]   level_reg, level_next;
    logic            pop;
    logic [LW-1:0]   level_after_pop;

    assign out_valid       = level_reg != '0;
    assign out_data        = mem_reg[rd_ptr_reg];
    assign pop             = out_valid && !out_stall;
    assign level_after_pop = level_reg - LW'(pop);
    // space for a worst-case request this cycle
    assign room            = level_after_pop <= LW'(FIFO_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + AW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign level_next  = level_after_pop + LW'(push.count);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + AW'(1)] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule
